// File: hw/rtl/lrq_pkg.sv
`timescale 1ns / 1ps

package lrq_pkg;

    // Fixed field widths of the command and reply items
    localparam int ADDR_W  = 48;
    localparam int MODE_W  = 2;
    localparam int REPLY_W = 3;

    // Command codes carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_PING    = 2'd0,
        MODE_REQUEST = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_OTHER   = 2'd3
    } t_mode;

    // Reply codes
    typedef enum logic [REPLY_W-1:0] {
        RPL_PONG    = 3'd0,
        RPL_GRANTED = 3'd1,
        RPL_DENIED  = 3'd2,
        RPL_ACK     = 3'd3,
        RPL_ERROR   = 3'd4
    } t_reply;

    // Command sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FETCH,
        ST_ACK
    } t_state;

    // One reply item as held in the output register
    typedef struct packed {
        logic [ADDR_W-1:0] dest_addr;
        t_reply            reply;
        logic              dropped;
        logic              last;
    } t_rsp;

endpackage

// File: hw/rtl/lrq_cmd_if.sv
`timescale 1ns / 1ps

interface lrq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [lrq_pkg::MODE_W-1:0]  mode;
    logic                        resource;
    logic [lrq_pkg::ADDR_W-1:0]  client_addr;

    modport source (output valid, output mode, output resource, output client_addr,
                    input ready);
    modport sink   (input valid, input mode, input resource, input client_addr,
                    output ready);
endinterface

// File: hw/rtl/lrq_rsp_if.sv
`timescale 1ns / 1ps

interface lrq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [lrq_pkg::ADDR_W-1:0]  dest_addr;
    logic [lrq_pkg::REPLY_W-1:0] reply;
    logic                        dropped;
    logic                        last;

    modport source (output valid, output dest_addr, output reply, output dropped,
                    output last, input ready);
    modport sink   (input valid, input dest_addr, input reply, input dropped,
                    input last, output ready);
endinterface

// File: hw/rtl/lrq_ram.sv
`timescale 1ns / 1ps

module lrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: hw/rtl/resource_lock_with_wait_queue_core.sv
`timescale 1ns / 1ps

// Channel   Modport  Payload                                Direction
// i_cmd     sink     mode, resource, client_addr            command items in
// o_rsp     source   dest_addr, reply, dropped, last        reply items out
//
// A command that yields one reply passes through IDLE and LOOKUP; a release that
// hands the lock to a waiter goes on through FETCH, where the wait-memory read
// lands and the grant is loaded, then ACK. New commands are taken only in IDLE.
// The per-resource lock record is read once per command and written back at most
// once, in LOOKUP; the record memory read is registered and used in LOOKUP.
// Reset clears the record valid flags at once; an unwritten record reads as a
// free lock with an empty queue. No clearing pass is needed.
// A full output register holds the sequencer until o_rsp.ready frees it.

module resource_lock_with_wait_queue_core #(
    parameter int NUM_RESOURCES = 2,
    parameter int QUEUE_DEPTH   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lrq_cmd_if.sink   i_cmd,
    lrq_rsp_if.source o_rsp
);

    localparam int RES_W  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int WDEPTH = NUM_RESOURCES * QUEUE_DEPTH;
    localparam int WA_W   = $clog2(WDEPTH);

    typedef struct packed {
        logic             held;
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] count;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

    lrq_pkg::t_state r_state, n_state;

    logic [lrq_pkg::MODE_W-1:0] r_mode;
    logic                       r_res;
    logic [lrq_pkg::ADDR_W-1:0] r_client;
    logic [NUM_RESOURCES-1:0]   r_ctl_vld;
    logic                       r_rd_vld;
    lrq_pkg::t_rsp              r_out, n_out;
    logic                       r_out_valid;

    logic                       w_accept;
    logic                       w_load;
    logic                       w_load_ok;
    logic [RES_W-1:0]           w_res_idx;
    logic [RES_W-1:0]           w_in_idx;
    logic [CTL_W-1:0]           w_ctl_rdata;
    t_ctl                       w_ctl;
    t_ctl                       w_ctl_next;
    logic                       w_ctl_we;
    logic [WA_W-1:0]            w_base;
    logic                       w_wait_we;
    logic                       w_wait_re;
    logic [WA_W-1:0]            w_wait_addr;
    logic [lrq_pkg::ADDR_W-1:0] w_wait_rdata;
    logic                       w_is_err;

    assign w_accept  = i_cmd.valid && i_cmd.ready;
    assign w_in_idx  = RES_W'(i_cmd.resource);
    assign w_res_idx = RES_W'(r_res);
    assign w_load_ok = !r_out_valid || o_rsp.ready;
    assign w_base    = WA_W'(w_res_idx) * WA_W'(QUEUE_DEPTH);
    assign w_ctl     = r_rd_vld ? t_ctl'(w_ctl_rdata) : '0;
    assign w_is_err  = (r_mode == lrq_pkg::MODE_OTHER) || (int'(r_res) >= NUM_RESOURCES);

    // Per-resource lock record: held flag, ring pointers, waiter count
    lrq_ram #(
        .WIDTH (CTL_W),
        .DEPTH (NUM_RESOURCES)
    ) u_ctl_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctl_we),
        .i_waddr (w_res_idx),
        .i_wdata (CTL_W'(w_ctl_next)),
        .i_re    (w_accept),
        .i_raddr (w_in_idx),
        .o_rdata (w_ctl_rdata)
    );

    // Waiter rings, one block of QUEUE_DEPTH entries per resource
    lrq_ram #(
        .WIDTH (lrq_pkg::ADDR_W),
        .DEPTH (WDEPTH)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (w_wait_we),
        .i_waddr (w_wait_addr),
        .i_wdata (r_client),
        .i_re    (w_wait_re),
        .i_raddr (w_wait_addr),
        .o_rdata (w_wait_rdata)
    );

    // Advance the state, track record validity and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrq_pkg::ST_IDLE;
            r_ctl_vld   <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_rd_vld <= r_ctl_vld[w_in_idx];
            end
            if (w_ctl_we) begin
                r_ctl_vld[w_res_idx] <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_cmd.mode;
            r_res    <= i_cmd.resource;
            r_client <= i_cmd.client_addr;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    // Sequencer: decide, update the record, queue or dequeue, emit replies
    always_comb begin
        n_state     = r_state;
        n_out       = '0;
        n_out.reply = lrq_pkg::RPL_PONG;
        w_load      = 1'b0;
        w_ctl_next  = w_ctl;
        w_ctl_we    = 1'b0;
        w_wait_we   = 1'b0;
        w_wait_re   = 1'b0;
        w_wait_addr = w_base + WA_W'(w_ctl.tail);
        i_cmd.ready = 1'b0;

        unique case (r_state)
            lrq_pkg::ST_IDLE: begin
                i_cmd.ready = 1'b1;
                if (w_accept) begin
                    n_state = lrq_pkg::ST_LOOKUP;
                end
            end
            lrq_pkg::ST_LOOKUP: begin
                if (w_load_ok) begin
                    n_out.dest_addr = r_client;
                    n_out.last      = 1'b1;
                    n_state         = lrq_pkg::ST_IDLE;
                    w_load          = 1'b1;
                    priority if (r_mode == lrq_pkg::MODE_PING) begin
                        n_out.reply = lrq_pkg::RPL_PONG;
                    end else if (w_is_err) begin
                        n_out.reply = lrq_pkg::RPL_ERROR;
                    end else if (r_mode == lrq_pkg::MODE_REQUEST) begin
                        priority if (!w_ctl.held) begin
                            w_ctl_next.held = 1'b1;
                            w_ctl_we        = 1'b1;
                            n_out.reply     = lrq_pkg::RPL_GRANTED;
                        end else if (w_ctl.count == CNT_W'(QUEUE_DEPTH)) begin
                            n_out.reply   = lrq_pkg::RPL_DENIED;
                            n_out.dropped = 1'b1;
                        end else begin
                            // enqueue at tail
                            w_wait_we        = 1'b1;
                            w_ctl_next.tail  = (w_ctl.tail == PTR_W'(QUEUE_DEPTH - 1)) ?
                                               '0 : w_ctl.tail + 1'b1;
                            w_ctl_next.count = w_ctl.count + 1'b1;
                            w_ctl_we         = 1'b1;
                            n_out.reply      = lrq_pkg::RPL_DENIED;
                        end
                    end else if (w_ctl.count == '0) begin
                        // release with no waiters frees the lock
                        w_ctl_next.held = 1'b0;
                        w_ctl_we        = 1'b1;
                        n_out.reply     = lrq_pkg::RPL_ACK;
                    end else begin
                        // release with waiters: dequeue head, grant from ST_FETCH
                        w_load           = 1'b0;
                        w_wait_re        = 1'b1;
                        w_wait_addr      = w_base + WA_W'(w_ctl.head);
                        w_ctl_next.head  = (w_ctl.head == PTR_W'(QUEUE_DEPTH - 1)) ?
                                           '0 : w_ctl.head + 1'b1;
                        w_ctl_next.count = w_ctl.count - 1'b1;
                        w_ctl_we         = 1'b1;
                        n_state          = lrq_pkg::ST_FETCH;
                    end
                end
            end
            lrq_pkg::ST_FETCH: begin
                // grant to the oldest waiter
                if (w_load_ok) begin
                    n_out.dest_addr = w_wait_rdata;
                    n_out.reply     = lrq_pkg::RPL_GRANTED;
                    n_out.last      = 1'b0;
                    w_load          = 1'b1;
                    n_state         = lrq_pkg::ST_ACK;
                end
            end
            lrq_pkg::ST_ACK: begin
                // acknowledge the releaser
                if (w_load_ok) begin
                    n_out.dest_addr = r_client;
                    n_out.reply     = lrq_pkg::RPL_ACK;
                    n_out.last      = 1'b1;
                    w_load          = 1'b1;
                    n_state         = lrq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lrq_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive the reply channel
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.dest_addr = r_out.dest_addr;
    assign o_rsp.reply     = r_out.reply;
    assign o_rsp.dropped   = r_out.dropped;
    assign o_rsp.last      = r_out.last;

    // Waiter count never passes the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl_we |-> (w_ctl_next.count <= CNT_W'(QUEUE_DEPTH)))
        else $error("waiter count overflow");

    // A ring is never written and read in the same cycle
    a_wait_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wait_we && w_wait_re))
        else $error("wait memory read and write collide");

    // Fetch is entered only from lookup
    a_fetch_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrq_pkg::ST_FETCH) |->
            ($past(r_state) == lrq_pkg::ST_LOOKUP || $past(r_state) == lrq_pkg::ST_FETCH))
        else $error("fetch state entered out of order");

    // Handover grant sits in the output register when the ACK step begins
    a_grant_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrq_pkg::ST_ACK && $past(r_state) == lrq_pkg::ST_FETCH) |->
            (r_out_valid && r_out.reply == lrq_pkg::RPL_GRANTED && !r_out.last))
        else $error("handover grant missing");

    // Only the handover grant is a non-final reply
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_out.reply == lrq_pkg::RPL_GRANTED))
        else $error("non-final reply is not a grant");

endmodule
